// ----- sv/assert_macros.svh -----
// Assertion macros for the distinct prime counter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define DPC_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DPC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/dpc_pkg.sv -----
// Package for the distinct prime counter: widths, payload structs and FSM state type.
// No dependencies; the files other than assert_macros.svh use it by scoped names.
`timescale 1ns / 1ps

package dpc_pkg;

  localparam int DATA_W        = 16;
  localparam int MAG_W         = 15;
  localparam int COUNT_W       = 8;
  localparam int SEEN_SIZE_DEF = 1024;
  localparam int DSR_W         = 8;
  localparam int SQ_W          = 17;
  localparam int MOD_STEPS     = 4;
  localparam int MOD_CYCLES    = DATA_W / MOD_STEPS;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     start_new;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               is_prime;
    logic               newly_seen;
    logic               out_of_range;
  } out_item_t;

  // Classified item as it waits between the front and back parts.
  typedef struct packed {
    logic             start_new;
    logic             lt_two;
    logic             oor;
    logic [MAG_W-1:0] mag;
  } q_item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DSR_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_WAIT,
    ST_RESOLVE,
    ST_LOOKUP,
    ST_EMIT
  } back_state_t;

endpackage

// ----- sv/dpc_fifo.sv -----
// Short queue of classified items between the front and back parts.
// Depends on dpc_pkg for the entry type, depth and status struct.
`timescale 1ns / 1ps

module dpc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dpc_pkg::q_item_t   push_item,
  input  logic               pop,
  output dpc_pkg::q_item_t   pop_item,
  output dpc_pkg::q_status_t status
);

  dpc_pkg::q_item_t                 q_mem_r [dpc_pkg::QDEPTH];
  logic [dpc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dpc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dpc_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  localparam logic [dpc_pkg::QPTR_W-1:0] LAST_PTR = dpc_pkg::QPTR_W'(dpc_pkg::QDEPTH - 1);
  localparam logic [dpc_pkg::QCNT_W-1:0] FULL_CNT = dpc_pkg::QCNT_W'(dpc_pkg::QDEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = q_mem_r[rd_ptr_r];
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == FULL_CNT);
  assign status.count = cnt_r;

endmodule

// ----- sv/dpc_mod.sv -----
// Iterative remainder unit: dividend modulo divisor, four restoring steps a cycle.
// Depends on dpc_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module dpc_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  dpc_pkg::mod_req_t req,
  output dpc_pkg::mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(dpc_pkg::MOD_CYCLES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(dpc_pkg::MOD_CYCLES - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [dpc_pkg::DSR_W-1:0]   rem_r, rem_nxt;
  logic [dpc_pkg::DATA_W-1:0]  dv_r, dv_nxt;
  logic [dpc_pkg::DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [dpc_pkg::DSR_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    dsr_nxt  = dsr_r;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dv_nxt   = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in the divisor width.
      for (int i = 0; i < dpc_pkg::MOD_STEPS; i++) begin
        trial  = {rem_nxt, dv_nxt[dpc_pkg::DATA_W-1]};
        dv_nxt = {dv_nxt[dpc_pkg::DATA_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr_r}) begin
          trial = trial - {1'b0, dsr_r};
        end
        rem_nxt = trial[dpc_pkg::DSR_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

// ----- sv/dpc_front.sv -----
// Front part: takes input items, classifies them and pushes them into the queue.
// Depends on dpc_pkg for the payload, queue entry and status structs.
`timescale 1ns / 1ps

module dpc_front #(
  parameter int SEEN_SIZE = dpc_pkg::SEEN_SIZE_DEF
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dpc_pkg::in_item_t     in_data,
  input  dpc_pkg::q_status_t    q_status,
  input  dpc_pkg::back_status_t back_status,
  output logic                  push,
  output dpc_pkg::q_item_t      push_item
);

  // Nothing is taken while the queue is full or the bitmap is being cleared after reset.
  assign in_stall = q_status.full | back_status.init_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_item.start_new = in_data.start_new;
    push_item.lt_two    = (in_data.value < 16'sd2);
    push_item.oor       = ~in_data.value[dpc_pkg::DATA_W-1] &&
                          (32'(in_data.value[dpc_pkg::MAG_W-1:0]) >= 32'(SEEN_SIZE));
    push_item.mag       = in_data.value[dpc_pkg::MAG_W-1:0];
  end

endmodule

// ----- sv/dpc_back.sv -----
// Back part: trial-division sequencer, seen bitmap memory, distinct count and result register.
// Depends on dpc_pkg and instantiates dpc_mod for the remainders.
`timescale 1ns / 1ps

module dpc_back #(
  parameter int SEEN_SIZE = dpc_pkg::SEEN_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpc_pkg::q_status_t    q_status,
  input  dpc_pkg::q_item_t      q_item,
  output logic                  pop,
  output dpc_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dpc_pkg::out_item_t    out_data
);

  localparam int IDX_W = $clog2(SEEN_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEEN_SIZE - 1);

  dpc_pkg::back_state_t          state_r, state_nxt;
  dpc_pkg::q_item_t              item_r, item_nxt;
  logic [dpc_pkg::DSR_W-1:0]     d_r, d_nxt;
  logic [dpc_pkg::SQ_W-1:0]      sq_r, sq_nxt;
  logic                          prime_r, prime_nxt;
  logic                          fresh_r, fresh_nxt;
  logic [dpc_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]              clr_idx_r, clr_idx_nxt;
  logic                          init_r, init_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dpc_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                          seen_mem [SEEN_SIZE];
  logic                          seen_rd_r;
  logic                          mem_we, mem_wdata, mem_re;
  logic [IDX_W-1:0]              mem_waddr, item_idx;

  dpc_pkg::mod_req_t             mod_req;
  dpc_pkg::mod_rsp_t             mod_rsp;

  dpc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign item_idx = IDX_W'(32'(item_r.mag));

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    fresh_nxt     = fresh_r;
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_idx_r;
    mem_wdata     = 1'b0;
    mem_re        = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = dpc_pkg::DATA_W'(item_r.mag);
    mod_req.divisor  = d_r;

    unique case (state_r)
      dpc_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          clr_idx_nxt = '0;
          init_nxt    = 1'b0;
          state_nxt   = init_r ? dpc_pkg::ST_IDLE : dpc_pkg::ST_TEST;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      dpc_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          item_nxt  = q_item;
          d_nxt     = dpc_pkg::DSR_W'(2);
          sq_nxt    = dpc_pkg::SQ_W'(4);
          fresh_nxt = 1'b0;
          if (q_item.start_new) begin
            count_nxt = '0;
            state_nxt = dpc_pkg::ST_CLEAR;
          end else begin
            state_nxt = dpc_pkg::ST_TEST;
          end
        end
      end
      dpc_pkg::ST_TEST: begin
        if (item_r.lt_two) begin
          prime_nxt = 1'b0;
          state_nxt = dpc_pkg::ST_RESOLVE;
        end else if (sq_r > dpc_pkg::SQ_W'(item_r.mag)) begin
          // No divisor up to the square root divides the value.
          prime_nxt = 1'b1;
          state_nxt = dpc_pkg::ST_RESOLVE;
        end else begin
          mod_req.start = 1'b1;
          state_nxt     = dpc_pkg::ST_WAIT;
        end
      end
      dpc_pkg::ST_WAIT: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem_zero) begin
            prime_nxt = 1'b0;
            state_nxt = dpc_pkg::ST_RESOLVE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + dpc_pkg::SQ_W'({d_r, 1'b1});
            state_nxt = dpc_pkg::ST_TEST;
          end
        end
      end
      dpc_pkg::ST_RESOLVE: begin
        if (prime_r && !item_r.oor) begin
          mem_re    = 1'b1;
          state_nxt = dpc_pkg::ST_LOOKUP;
        end else begin
          state_nxt = dpc_pkg::ST_EMIT;
        end
      end
      dpc_pkg::ST_LOOKUP: begin
        if (!seen_rd_r) begin
          mem_we    = 1'b1;
          mem_waddr = item_idx;
          mem_wdata = 1'b1;
          fresh_nxt = 1'b1;
          if (count_r != dpc_pkg::COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end
        state_nxt = dpc_pkg::ST_EMIT;
      end
      dpc_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.distinct_count = count_r;
          out_data_nxt.is_prime       = prime_r;
          out_data_nxt.newly_seen     = fresh_r;
          out_data_nxt.out_of_range   = item_r.oor;
          state_nxt                   = dpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpc_pkg::ST_CLEAR;
      count_r     <= '0;
      clr_idx_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_idx_r   <= clr_idx_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    prime_r    <= prime_nxt;
    fresh_r    <= fresh_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      seen_rd_r <= seen_mem[item_idx];
    end
  end

  assign status.init_busy = init_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

// ----- sv/distinct_prime_counter_top.sv -----
// Distinct prime counter: top level joining the front part, the queue and the back part.
// Depends on dpc_pkg, dpc_front, dpc_fifo, dpc_back (with dpc_mod) and assert_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one item per matrix element:
// a signed 16-bit value and a start_new flag that clears the seen bitmap and the
// distinct count before that element is counted. The result channel (out_valid,
// out_stall, out_data) returns exactly one item per input item, in order, with the
// running distinct count, is_prime, newly_seen and out_of_range.
// Each value of 2 or more is tested by trial division with divisors from 2 while
// d*d does not exceed the value. The remainder unit settles four quotient bits
// a cycle; a prime near 32767 needs 180 divisors. A value below 2 goes straight to
// its result without any division. An item with start_new first sweeps the bitmap
// memory. After reset the same sweep runs; in_stall stays high until it is done.
// A two-entry queue lets the front take items while the back part works, and the
// result register lets the back part finish its next item while a result is
// stalled; the receiver stalling only holds out_data and then backs up the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module distinct_prime_counter_top #(
  parameter int SEEN_SIZE = dpc_pkg::SEEN_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dpc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dpc_pkg::out_item_t out_data
);

  dpc_pkg::q_status_t    q_status;
  dpc_pkg::q_item_t      push_item;
  dpc_pkg::q_item_t      pop_item;
  dpc_pkg::back_status_t back_status;
  logic                  push;
  logic                  pop;

  // Front: classification of each accepted item.
  dpc_front #(
    .SEEN_SIZE (SEEN_SIZE)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_status    (q_status),
    .back_status (back_status),
    .push        (push),
    .push_item   (push_item)
  );

  // Queue that decouples the two parts.
  dpc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Back: primality test, bitmap lookup and result register.
  dpc_back #(
    .SEEN_SIZE (SEEN_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_item    (pop_item),
    .pop       (pop),
    .status    (back_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A freshly counted prime is always in range and leaves a nonzero count.
  `DPC_ASSERT_IMPLIES(a_fresh_consistent, out_valid && out_data.newly_seen,
    out_data.is_prime && !out_data.out_of_range && (out_data.distinct_count != '0),
    "newly_seen result is inconsistent with its other fields")

  // No result or queued item can exist while the bitmap is cleared after reset.
  `DPC_ASSERT_IMPLIES(a_no_result_in_init, back_status.init_busy, !out_valid && q_status.empty,
    "result or queued item during the reset sweep")

  // The queue never holds more items than its depth.
  `DPC_ASSERT_HOLDS(a_queue_bound, 32'(q_status.count) <= dpc_pkg::QDEPTH,
    "queue occupancy beyond its depth")

endmodule

// ----- test/tb_distinct_prime_counter_top.sv -----
// Testbench for distinct_prime_counter_top: directed and random matrix streams with a
// running prediction of the distinct-prime tally, checked on every accepted result item.
// Depends on dpc_pkg and the distinct_prime_counter_top RTL only.
`timescale 1ns / 1ps

module tb_distinct_prime_counter_top;

  // The block is built with its default bitmap size, and the tally model uses the same.
  localparam int SEEN          = dpc_pkg::SEEN_SIZE_DEF;
  localparam int REPORT_MAX    = 10;
  // The drain margin covers the work of a prime near 32767 plus a bitmap sweep.
  localparam int DRAIN_CYCLES  = 2500;
  localparam int RANDOM_ITEMS  = 555;
  // The run limit: well above the slowest legal run of every item at its worst.
  localparam int RUN_LIMIT_NS  = 30_000_000;

  // Receiver stall patterns; each is held for a random stretch of cycles.
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_HOLD  = 3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  dpc_pkg::in_item_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  dpc_pkg::out_item_t out_data;

  distinct_prime_counter_top #(
    .SEEN_SIZE(SEEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Our own copy of the block's state: which primes have been seen in the current
  // matrix, and how many distinct ones there are (saturating at COUNT_MAX).
  bit [SEEN-1:0]               seen_primes;
  logic [dpc_pkg::COUNT_W-1:0] prime_tally;

  // Result items predicted at input acceptance, oldest first.
  dpc_pkg::out_item_t awaited_results[$];

  int mismatches = 0;
  int burst_left = 1;
  int rx_mode    = RX_FREE;
  int rx_left    = 0;

  // Plain trial division; stopping at d*d > n gives the same answer as going to n-1.
  function automatic bit trial_prime(int n);
    if (n < 2) return 1'b0;
    for (int d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Updates the seen bitmap and tally for one element and returns its expected result.
  // Values at or above the bitmap size are reported as prime or not, but never counted.
  function automatic dpc_pkg::out_item_t tally_element(dpc_pkg::in_item_t it);
    int                 v;
    dpc_pkg::out_item_t r;
    v = $signed(it.value);
    if (it.start_new) begin
      seen_primes = '0;
      prime_tally = '0;
    end
    r              = '0;
    r.is_prime     = trial_prime(v);
    r.out_of_range = (v >= SEEN);
    if (r.is_prime && !r.out_of_range && !seen_primes[v]) begin
      seen_primes[v] = 1'b1;
      r.newly_seen   = 1'b1;
      if (prime_tally != dpc_pkg::COUNT_MAX) prime_tally++;
    end
    r.distinct_count = prime_tally;
    return r;
  endfunction

  // Random element value. Most values stay inside the bitmap so that primes repeat and
  // the tally moves; a few are large (slow to test) or negative, and some are fully random
  // so that every bit of the field is exercised.
  function automatic logic [dpc_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return dpc_pkg::DATA_W'($urandom_range(0, 1100));
    if (sel < 55) return dpc_pkg::DATA_W'($urandom_range(0, 60));
    if (sel < 65) return 16'h8000 | dpc_pkg::DATA_W'($urandom_range(0, 32767));
    if (sel < 75) return dpc_pkg::DATA_W'($urandom);
    if (sel < 85) return dpc_pkg::DATA_W'($urandom_range(1000, 1100));
    if (sel < 91) return dpc_pkg::DATA_W'($urandom_range(32000, 32767));
    return dpc_pkg::DATA_W'($urandom_range(0, 30));
  endfunction

  // Drives one item at the falling edge and holds it until the block accepts it at a
  // rising edge. The expectation is recorded at acceptance. The sender works in bursts:
  // when a burst runs out, valid drops for a random gap (or not at all).
  task automatic send_element(input logic [dpc_pkg::DATA_W-1:0] value, input logic start);
    int gap;
    @(negedge clk);
    in_valid          = 1'b1;
    in_data.value     = value;
    in_data.start_new = start;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    awaited_results.push_back(tally_element(in_data));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Field extremes and the special cases: values below two, the largest prime inside
  // the bitmap, the first values outside it, and the largest positive 16-bit prime
  // (which is out of range yet still reported as prime).
  task automatic test_edge_values();
    send_element(16'd0, 1'b1);
    send_element(16'h8000, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'd0, 1'b0);
    send_element(16'd1, 1'b0);
    send_element(16'd2, 1'b0);
    send_element(16'd3, 1'b0);
    send_element(16'd4, 1'b0);
    send_element(16'd1021, 1'b0);
    send_element(16'd1022, 1'b0);
    send_element(16'd1023, 1'b0);
    send_element(16'd1024, 1'b0);
    send_element(16'd1031, 1'b0);
    send_element(16'd32749, 1'b0);
    send_element(16'h7FFF, 1'b0);
  endtask

  // Repeated primes must not move the tally; a start flag clears it before its own
  // element is counted, whether that element is prime or not.
  task automatic test_repeats_and_restart();
    send_element(16'd2, 1'b0);
    send_element(16'd1021, 1'b0);
    send_element(16'd97, 1'b0);
    send_element(16'd97, 1'b0);
    send_element(16'd97, 1'b1);
    send_element(16'd5, 1'b1);
    send_element(16'hFFF9, 1'b1);
  endtask

  // Random matrices: each begins with a start flag and then carries random elements;
  // once in a while a stray start flag falls in the middle of a matrix.
  task automatic test_random_matrices();
    int sent;
    int mat_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mat_len = $urandom_range(4, 40);
      for (int i = 0; i < mat_len; i++) begin
        send_element(pick_value(), (i == 0) || ($urandom_range(0, 99) == 0));
        sent++;
      end
    end
  endtask

  // Receiver stall pattern, independent of the sender: free running, light or heavy
  // random stalls, and solid holds, each kept for a random number of cycles.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_FREE, RX_HOLD);
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 60) : $urandom_range(1, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall = 1'b0;
      RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall = ($urandom_range(0, 1) == 0);
      default:  out_stall = 1'b1;
    endcase
  end

  // Every accepted result item is matched against the oldest prediction, field by field.
  always @(posedge clk) begin
    dpc_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Result item with nothing pending: count=%0d prime=%b new=%b oor=%b",
                   out_data.distinct_count, out_data.is_prime, out_data.newly_seen,
                   out_data.out_of_range);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.distinct_count !== want.distinct_count ||
            out_data.is_prime !== want.is_prime ||
            out_data.newly_seen !== want.newly_seen ||
            out_data.out_of_range !== want.out_of_range) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"Mismatch: expected count=%0d prime=%b new=%b oor=%b, ",
                      "got count=%0d prime=%b new=%b oor=%b"},
                     want.distinct_count, want.is_prime, want.newly_seen, want.out_of_range,
                     out_data.distinct_count, out_data.is_prime, out_data.newly_seen,
                     out_data.out_of_range);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[distinct_prime_counter_top] ERROR");
    $finish;
  end

  // Main sequence: one reset, the tests in turn, then a drain and the verdict.
  initial begin
    seen_primes = '0;
    prime_tally = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_values();
    test_repeats_and_restart();
    test_random_matrices();

    @(negedge clk);
    in_valid = 1'b0;

    // Wait for every predicted item, then give the block time to show any extra one.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[distinct_prime_counter_top] OK");
    end else begin
      $display("[distinct_prime_counter_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/dpc_pkg.sv
sv/dpc_fifo.sv
sv/dpc_mod.sv
sv/dpc_front.sv
sv/dpc_back.sv
sv/distinct_prime_counter_top.sv
test/tb_distinct_prime_counter_top.sv
